### hw/rtl/agc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_pkg: shared definitions of the anagram group classifier
// sizes, derived widths and the request/result structs passed between modules
// ----------------------------------------------------------------------------
package agc_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int MAX_GROUPS    = 64;
	localparam int COUNT_BITS    = 8;

	// fixed port field widths
	localparam int LETTER_W      = 5;
	localparam int GROUP_INDEX_W = 6;

	// derived widths
	localparam int CNT_AW    = $clog2(ALPHABET_SIZE);
	localparam int SIG_DEPTH = MAX_GROUPS * ALPHABET_SIZE;
	localparam int SIG_AW    = $clog2(SIG_DEPTH);
	localparam int BASE_W    = $clog2(SIG_DEPTH + 1);
	localparam int GRP_W     = $clog2(MAX_GROUPS + 1);

	// letter count store access
	typedef struct packed {
		logic [CNT_AW-1:0]     rd_addr;
		logic                  wr_en;
		logic [CNT_AW-1:0]     wr_addr;
		logic [COUNT_BITS-1:0] wr_data;
		logic                  clear;
	} cnt_req_t;

	// signature store access
	typedef struct packed {
		logic [SIG_AW-1:0]     rd_addr;
		logic                  wr_en;
		logic [SIG_AW-1:0]     wr_addr;
		logic [COUNT_BITS-1:0] wr_data;
	} sig_req_t;

	// one finished word
	typedef struct packed {
		logic [GROUP_INDEX_W-1:0] group_index;
		logic                     new_group;
		logic                     table_full;
		logic                     count_saturated;
	} res_t;

endpackage

### hw/rtl/agc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_ram: generic single-clock ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module agc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### hw/rtl/agc_count_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_count_store: per-letter counts of the word in progress
// ram with one valid bit per letter; a cleared letter reads as zero
// ----------------------------------------------------------------------------
module agc_count_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  agc_pkg::cnt_req_t            req,
	output logic [agc_pkg::COUNT_BITS-1:0] rd_count
);
	import agc_pkg::*;

	logic [ALPHABET_SIZE-1:0] vld_q;
	logic                     rd_vld_s1;
	logic [COUNT_BITS-1:0]    ram_rdata;

	agc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (ALPHABET_SIZE)
	) u_ram (
		.clk     (clk),
		.wr_en   (req.wr_en),
		.wr_addr (req.wr_addr),
		.wr_data (req.wr_data),
		.rd_addr (req.rd_addr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[req.rd_addr];
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_count = rd_vld_s1 ? ram_rdata : '0;

endmodule

### hw/rtl/agc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_seq: item sequencer
// counts letters, walks stored signatures at word end, appends new groups
// ----------------------------------------------------------------------------
module agc_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [agc_pkg::LETTER_W-1:0]   letter,
	input  logic                           no_letter,
	input  logic                           last_of_word,
	output agc_pkg::cnt_req_t              cnt_req,
	input  logic [agc_pkg::COUNT_BITS-1:0] cnt_rd,
	output agc_pkg::sig_req_t              sig_req,
	input  logic [agc_pkg::COUNT_BITS-1:0] sig_rd,
	output logic                           res_valid,
	input  logic                           res_ready,
	output agc_pkg::res_t                  res
);
	import agc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_LWR      = 7'b0000010,
		S_SRCH_RD  = 7'b0000100,
		S_SRCH_CMP = 7'b0001000,
		S_COPY_RD  = 7'b0010000,
		S_COPY_WR  = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
	localparam logic [CNT_AW-1:0]     K_LAST   = CNT_AW'(ALPHABET_SIZE - 1);
	localparam logic [BASE_W-1:0]     BASE_INC = BASE_W'(ALPHABET_SIZE);
	localparam logic [GRP_W-1:0]      GRP_CAP  = GRP_W'(MAX_GROUPS);

	state_t            state_q;
	logic [CNT_AW-1:0] letter_q;
	logic              last_q;
	logic              sat_q;
	logic [GRP_W-1:0]  used_q;
	logic [GRP_W-1:0]  g_q;
	logic [BASE_W-1:0] base_q;
	logic [CNT_AW-1:0] k_q;
	res_t              res_q;

	logic              in_acc;
	logic              letter_ok;
	logic [SIG_AW-1:0] sig_addr;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign letter_ok = !no_letter && (32'(letter) < ALPHABET_SIZE);
	assign sig_addr  = SIG_AW'(base_q + BASE_W'(k_q));

	always_comb begin
		cnt_req.rd_addr = (state_q == S_IDLE) ? CNT_AW'(letter) : k_q;
		cnt_req.wr_en   = (state_q == S_LWR) && (cnt_rd != CNT_MAX);
		cnt_req.wr_addr = letter_q;
		cnt_req.wr_data = cnt_rd + COUNT_BITS'(1);
		cnt_req.clear   = (state_q == S_DONE) && res_ready;

		sig_req.rd_addr = sig_addr;
		sig_req.wr_en   = (state_q == S_COPY_WR);
		sig_req.wr_addr = sig_addr;
		sig_req.wr_data = cnt_rd;
	end

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sat_q   <= 1'b0;
			used_q  <= '0;
			g_q     <= '0;
			base_q  <= '0;
			k_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						letter_q <= CNT_AW'(letter);
						last_q   <= last_of_word;
						if (letter_ok) begin
							state_q <= S_LWR;
						end else if (last_of_word) begin
							g_q     <= '0;
							base_q  <= '0;
							k_q     <= '0;
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_LWR: begin
					// count saturates at its top value
					if (cnt_rd == CNT_MAX) begin
						sat_q <= 1'b1;
					end
					if (last_q) begin
						g_q     <= '0;
						base_q  <= '0;
						k_q     <= '0;
						state_q <= S_SRCH_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SRCH_RD: begin
					if (g_q == used_q) begin
						if (used_q == GRP_CAP) begin
							res_q.group_index     <= '0;
							res_q.new_group       <= 1'b0;
							res_q.table_full      <= 1'b1;
							res_q.count_saturated <= sat_q;
							state_q               <= S_DONE;
						end else begin
							k_q     <= '0;
							state_q <= S_COPY_RD;
						end
					end else begin
						state_q <= S_SRCH_CMP;
					end
				end
				S_SRCH_CMP: begin
					if (sig_rd != cnt_rd) begin
						// first mismatch ends this group
						g_q     <= g_q + GRP_W'(1);
						base_q  <= base_q + BASE_INC;
						k_q     <= '0;
						state_q <= S_SRCH_RD;
					end else if (k_q == K_LAST) begin
						res_q.group_index     <= GROUP_INDEX_W'(g_q);
						res_q.new_group       <= 1'b0;
						res_q.table_full      <= 1'b0;
						res_q.count_saturated <= sat_q;
						state_q               <= S_DONE;
					end else begin
						k_q     <= k_q + CNT_AW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_COPY_RD: begin
					state_q <= S_COPY_WR;
				end
				S_COPY_WR: begin
					if (k_q == K_LAST) begin
						res_q.group_index     <= GROUP_INDEX_W'(g_q);
						res_q.new_group       <= 1'b1;
						res_q.table_full      <= 1'b0;
						res_q.count_saturated <= sat_q;
						used_q                <= used_q + GRP_W'(1);
						state_q               <= S_DONE;
					end else begin
						k_q     <= k_q + CNT_AW'(1);
						state_q <= S_COPY_RD;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						sat_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	ap_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= GRP_CAP)
		else $error("group count beyond table size");

	ap_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		g_q <= used_q)
		else $error("search walked past the last group");

	ap_copy_tail: assert property (@(posedge clk) disable iff (!arst_n)
		sig_req.wr_en |-> (g_q == used_q && used_q != GRP_CAP))
		else $error("signature write outside the free slot");

	ap_full_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.table_full) |-> (used_q == GRP_CAP && !res_q.new_group))
		else $error("table full reported below capacity");
`endif

endmodule

### hw/rtl/anagram_group_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_group_classifier: groups words by letter-count signature
// letters are counted per word; at word end the count vector is compared
// against stored group signatures and matched or appended as a new group
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid/in_stall   | letter, no_letter, last_of_word
//  out     | out_valid/out_stall | group_index, new_group, table_full,
//          |                     | count_saturated (one beat per word end)
//
//  steps: a counted letter is a count ram read, then a write back; an item
//  without a letter writes no count. at a word end each stored group is
//  compared by a read then a compare per letter up to its first mismatch; a new
//  group adds a step to find the free slot and a read then a write per letter
//  for the copy, a full table only that step. the result then goes to the
//  output register. the single signature ram read port sets this.
//  reset: no clearing pass; count valid bits clear at once, signatures are
//  only read below the group count.
//  stalls: the output register holds one beat, so input is taken while a
//  result waits; a second word end waits until that beat leaves.
//
module anagram_group_classifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [agc_pkg::LETTER_W-1:0]        letter,
	input  logic                                no_letter,
	input  logic                                last_of_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [agc_pkg::GROUP_INDEX_W-1:0]   group_index,
	output logic                                new_group,
	output logic                                table_full,
	output logic                                count_saturated
);
	import agc_pkg::*;

	cnt_req_t              cnt_req;
	sig_req_t              sig_req;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic [COUNT_BITS-1:0] sig_rd;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res;

	logic                  out_valid_q;
	res_t                  out_q;

	// per-letter counts of the current word
	agc_count_store u_cnt (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (cnt_req),
		.rd_count (cnt_rd)
	);

	// one entry per letter per group, group g at rows g*26 .. g*26+25
	agc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (SIG_DEPTH)
	) u_sig_ram (
		.clk     (clk),
		.wr_en   (sig_req.wr_en),
		.wr_addr (sig_req.wr_addr),
		.wr_data (sig_req.wr_data),
		.rd_addr (sig_req.rd_addr),
		.rd_data (sig_rd)
	);

	agc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.letter       (letter),
		.no_letter    (no_letter),
		.last_of_word (last_of_word),
		.cnt_req      (cnt_req),
		.cnt_rd       (cnt_rd),
		.sig_req      (sig_req),
		.sig_rd       (sig_rd),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// output register takes a result when empty or when its beat leaves
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign group_index     = out_q.group_index;
	assign new_group       = out_q.new_group;
	assign table_full      = out_q.table_full;
	assign count_saturated = out_q.count_saturated;

endmodule
